@@ hdl/stmc_pkg.sv @@
// ----------------------------------------------------------------------------
// stmc_pkg
// Shared types and constants of the sun tracker motor controller: activity
// codes, scan phases, configuration register indexes and reset values.
// ----------------------------------------------------------------------------
package stmc_pkg;

    typedef enum logic [2:0] {
        ACT_IDLE    = 3'd0,
        ACT_SUNSET  = 3'd1,
        ACT_SUNRISE = 3'd2,
        ACT_CENTER  = 3'd3,
        ACT_LOW     = 3'd4,
        ACT_DARK    = 3'd5,
        ACT_LIMIT   = 3'd6,
        ACT_EXHAUST = 3'd7
    } activity_t;

    typedef enum logic [1:0] {
        PHASE_DECIDE  = 2'd0,
        PHASE_SUNSET  = 2'd1,
        PHASE_SUNRISE = 2'd2
    } scan_phase_t;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 8;
    localparam int COUNT_BITS     = 3;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_MOTOR_SPEED     = 3'd0,
        CFG_DARK_LEVEL      = 3'd1,
        CFG_LOW_LIGHT_INIT  = 3'd2,
        CFG_THRESHOLD_INIT  = 3'd3,
        CFG_THRESHOLD_STEP  = 3'd4,
        CFG_THRESHOLD_FLOOR = 3'd5,
        CFG_SCAN_LIMIT      = 3'd6
    } cfg_index_t;

    localparam logic [7:0] MOTOR_SPEED_RST     = 8'd220;
    localparam logic [7:0] DARK_LEVEL_RST      = 8'd170;
    localparam logic [7:0] LOW_LIGHT_INIT_RST  = 8'd210;
    localparam logic [7:0] THRESHOLD_INIT_RST  = 8'd245;
    localparam logic [7:0] THRESHOLD_STEP_RST  = 8'd15;
    localparam logic [7:0] THRESHOLD_FLOOR_RST = 8'd200;
    localparam logic [2:0] SCAN_LIMIT_RST      = 3'd3;

    // x / 10 as (x * 52429) >> 19, exact for x below 81920
    localparam logic [15:0] DIV10_RECIP = 16'd52429;
    localparam int          DIV10_SHIFT = 19;

    localparam int RESULT_BITS = 16;

endpackage

@@ hdl/sun_tracker_motor_controller.sv @@
// ----------------------------------------------------------------------------
// sun_tracker_motor_controller
// One motor decision per averaged sensor sample set: manual jog or automatic
// sunset/sunrise scanning with ambient light classification.
//
//   channel   direction  ports                          word
//   s_        in         s_tvalid s_tready s_tdata      one sample set
//   m_        out        m_tvalid m_tready m_tdata      one motor command
//   cfg_      in         cfg_valid cfg_ready cfg_index  one register write
//                        cfg_data
//
// One word per cycle sustained while m_tready stays high; a word passes the
// input register, then the decision logic into the result register.
// Reset (aresetn low, synchronous) restores register defaults and state.
// A stalled result holds in the result register while the input register
// still takes one more word; the decision fires only when the result
// register is free.
// ----------------------------------------------------------------------------
module sun_tracker_motor_controller #(
    parameter int LEVEL_BITS = 8
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // pot_level, track_level, ambient_level, mode_pressed, left_pressed,
    // right_pressed, sunrise_stop, sunset_stop
    input  logic [((3*LEVEL_BITS+5+7)/8)*8-1:0]    s_tdata,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // brake_on, motor_dir, motor_duty[7:0], auto_active, activity[2:0]
    output logic [stmc_pkg::RESULT_BITS-1:0]       m_tdata,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [stmc_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [stmc_pkg::CFG_DATA_BITS-1:0]     cfg_data
);
    import stmc_pkg::*;

    localparam int L = LEVEL_BITS;

    logic [7:0] motor_speed_reg, dark_level_reg, low_light_init_reg;
    logic [7:0] threshold_init_reg, threshold_step_reg, threshold_floor_reg;
    logic [COUNT_BITS-1:0] scan_limit_reg;

    logic              auto_mode_reg, auto_mode_next;
    scan_phase_t       scan_phase_reg, scan_phase_next;
    logic [L-1:0]      low_light_level_reg, low_light_level_next;
    logic [L-1:0]      center_threshold_reg, center_threshold_next;
    logic [COUNT_BITS-1:0] scan_count_reg, scan_count_next;
    logic              mode_prev_reg, mode_prev_next;
    logic              last_dir_reg, last_dir_next;

    logic              in_valid_reg;
    logic [L-1:0]      pot_reg, track_reg, ambient_reg;
    logic              mode_reg, left_reg, right_reg, sunrise_reg, sunset_reg;

    logic              out_valid_reg;
    logic [RESULT_BITS-1:0] out_data_reg;

    logic              advance;
    logic              brake;
    activity_t         act;
    logic [L+15:0]     div_prod;
    logic [L-1:0]      pot_div10;
    logic [L-1:0]      centered_level;
    logic [L-1:0]      dark_ext, floor_ext, step_ext;

    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            motor_speed_reg     <= MOTOR_SPEED_RST;
            dark_level_reg      <= DARK_LEVEL_RST;
            low_light_init_reg  <= LOW_LIGHT_INIT_RST;
            threshold_init_reg  <= THRESHOLD_INIT_RST;
            threshold_step_reg  <= THRESHOLD_STEP_RST;
            threshold_floor_reg <= THRESHOLD_FLOOR_RST;
            scan_limit_reg      <= SCAN_LIMIT_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_MOTOR_SPEED:     motor_speed_reg     <= cfg_data;
                CFG_DARK_LEVEL:      dark_level_reg      <= cfg_data;
                CFG_LOW_LIGHT_INIT:  low_light_init_reg  <= cfg_data;
                CFG_THRESHOLD_INIT:  threshold_init_reg  <= cfg_data;
                CFG_THRESHOLD_STEP:  threshold_step_reg  <= cfg_data;
                CFG_THRESHOLD_FLOOR: threshold_floor_reg <= cfg_data;
                CFG_SCAN_LIMIT:      scan_limit_reg      <= cfg_data[COUNT_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            pot_reg     <= s_tdata[L-1:0];
            track_reg   <= s_tdata[2*L-1:L];
            ambient_reg <= s_tdata[3*L-1:2*L];
            mode_reg    <= s_tdata[3*L];
            left_reg    <= s_tdata[3*L+1];
            right_reg   <= s_tdata[3*L+2];
            sunrise_reg <= s_tdata[3*L+3];
            sunset_reg  <= s_tdata[3*L+4];
        end
    end

    assign div_prod       = (L+16)'(pot_reg) * (L+16)'(DIV10_RECIP);
    assign pot_div10      = L'(div_prod >> DIV10_SHIFT);
    assign centered_level = ambient_reg - pot_div10;
    assign dark_ext       = L'(dark_level_reg);
    assign floor_ext      = L'(threshold_floor_reg);
    assign step_ext       = L'(threshold_step_reg);

    // decision for the word in the input register
    always_comb begin
        auto_mode_next        = auto_mode_reg;
        scan_phase_next       = scan_phase_reg;
        low_light_level_next  = low_light_level_reg;
        center_threshold_next = center_threshold_reg;
        scan_count_next       = scan_count_reg;
        last_dir_next         = last_dir_reg;
        mode_prev_next        = mode_reg;
        brake                 = 1'b1;
        act                   = ACT_IDLE;

        if (mode_reg) begin
            if (!mode_prev_reg) begin
                auto_mode_next = !auto_mode_reg;
                if (!auto_mode_reg) begin
                    scan_count_next = '0;
                    scan_phase_next = PHASE_DECIDE;
                end
            end
        end else if (!auto_mode_reg) begin
            if (left_reg) begin
                last_dir_next = 1'b1;
                if (sunset_reg) begin
                    act = ACT_LIMIT;
                end else begin
                    brake = 1'b0;
                    act   = ACT_SUNSET;
                end
            end else if (right_reg) begin
                last_dir_next = 1'b0;
                if (sunrise_reg) begin
                    act = ACT_LIMIT;
                end else begin
                    brake = 1'b0;
                    act   = ACT_SUNRISE;
                end
            end
        end else if (ambient_reg <= dark_ext) begin
            low_light_level_next  = L'(low_light_init_reg);
            center_threshold_next = L'(threshold_init_reg);
            scan_count_next       = '0;
            scan_phase_next       = PHASE_DECIDE;
            act                   = ACT_DARK;
        end else if (ambient_reg <= low_light_level_reg) begin
            scan_count_next = '0;
            scan_phase_next = PHASE_DECIDE;
            act             = ACT_LOW;
        end else begin
            if (scan_phase_reg == PHASE_DECIDE) begin
                if (scan_count_next >= scan_limit_reg &&
                    center_threshold_next > floor_ext) begin
                    scan_count_next       = '0;
                    center_threshold_next = (center_threshold_next > step_ext) ?
                                            center_threshold_next - step_ext : '0;
                end
                if (!sunset_reg && scan_count_next < scan_limit_reg) begin
                    scan_count_next = scan_count_next + COUNT_BITS'(1);
                    scan_phase_next = PHASE_SUNSET;
                end else if (!sunrise_reg && scan_count_next < scan_limit_reg) begin
                    scan_count_next = scan_count_next + COUNT_BITS'(1);
                    scan_phase_next = PHASE_SUNRISE;
                end else begin
                    scan_phase_next = PHASE_DECIDE;
                end
                if (scan_phase_next == PHASE_DECIDE) begin
                    act = (scan_count_next >= scan_limit_reg) ? ACT_EXHAUST : ACT_LIMIT;
                end
            end
            case (scan_phase_next)
                PHASE_SUNSET: begin
                    if (sunset_reg) begin
                        act = ACT_LIMIT;
                        if (!sunrise_reg && scan_count_next < scan_limit_reg) begin
                            scan_count_next = scan_count_next + COUNT_BITS'(1);
                            scan_phase_next = PHASE_SUNRISE;
                        end else begin
                            scan_phase_next = PHASE_DECIDE;
                        end
                    end else if (track_reg > center_threshold_next) begin
                        low_light_level_next = centered_level;
                        scan_count_next      = '0;
                        act                  = ACT_CENTER;
                    end else begin
                        last_dir_next = 1'b1;
                        brake         = 1'b0;
                        act           = ACT_SUNSET;
                    end
                end
                PHASE_SUNRISE: begin
                    if (sunrise_reg) begin
                        act             = ACT_LIMIT;
                        scan_phase_next = PHASE_DECIDE;
                    end else if (track_reg > center_threshold_next) begin
                        scan_count_next = '0;
                        act             = ACT_CENTER;
                        scan_phase_next = PHASE_DECIDE;
                    end else begin
                        last_dir_next = 1'b0;
                        brake         = 1'b0;
                        act           = ACT_SUNRISE;
                    end
                end
                PHASE_DECIDE: ;
                default: scan_phase_next = PHASE_DECIDE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            auto_mode_reg        <= 1'b0;
            scan_phase_reg       <= PHASE_DECIDE;
            low_light_level_reg  <= L'(LOW_LIGHT_INIT_RST);
            center_threshold_reg <= L'(THRESHOLD_INIT_RST);
            scan_count_reg       <= '0;
            mode_prev_reg        <= 1'b0;
            last_dir_reg         <= 1'b0;
        end else if (advance) begin
            auto_mode_reg        <= auto_mode_next;
            scan_phase_reg       <= scan_phase_next;
            low_light_level_reg  <= low_light_level_next;
            center_threshold_reg <= center_threshold_next;
            scan_count_reg       <= scan_count_next;
            mode_prev_reg        <= mode_prev_next;
            last_dir_reg         <= last_dir_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= {2'b00, act, auto_mode_next, motor_speed_reg,
                             last_dir_next, brake};
        end
    end

endmodule
